@@ hw/rtl/rkx_pkg.sv @@
// ----------------------------------------------------------------------------
// rkx_pkg
// Shared types and constants of the keyed XOR stream encoder.
// ----------------------------------------------------------------------------
package rkx_pkg;

   localparam logic [31:0] LcgMul  = 32'd214013;
   localparam logic [31:0] LcgAdd  = 32'd2531011;
   localparam logic [31:0] LcgMask = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      OP_DATA  = 2'd0,
      OP_AUTH  = 2'd1,
      OP_RESET = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      REG_ENABLE   = 2'd0,
      REG_MODE     = 2'd1,
      REG_EXPONENT = 2'd2,
      REG_MODULUS  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_POW,
      T_FIN
   } top_state_type;

   typedef enum logic [2:0] {
      PW_IDLE,
      PW_REDUCE,
      PW_STEP,
      PW_MUL,
      PW_SQR,
      PW_DONE
   } pw_state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] m;
   } mm_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } mm_rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] base;
      logic [31:0] exponent;
      logic [31:0] modulus;
   } pw_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } pw_rsp_type;

endpackage

@@ hw/rtl/rkx_modmul.sv @@
// ----------------------------------------------------------------------------
// rkx_modmul
// Interleaved modular multiplier: one multiplier bit per cycle over a 32-bit multiplier.
// ----------------------------------------------------------------------------
module rkx_modmul
   import rkx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  mm_req_type mm_req,
   output mm_rsp_type mm_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] m_ff, m_in;
   logic [31:0] r_ff, r_in;

   logic [33:0] sum;
   logic [33:0] m1;
   logic [33:0] m2;
   logic [33:0] diff1;
   logic [33:0] diff2;
   logic [31:0] r_next;

   always_comb begin
      sum   = {1'b0, r_ff, 1'b0} + (a_ff[31] ? {2'b00, b_ff} : 34'd0);
      m1    = {2'b00, m_ff};
      m2    = {1'b0, m_ff, 1'b0};
      diff1 = sum - m1;
      diff2 = sum - m2;
      if (sum >= m2) begin
         r_next = diff2[31:0];
      end else if (sum >= m1) begin
         r_next = diff1[31:0];
      end else begin
         r_next = sum[31:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      if (mm_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         a_in    = mm_req.a;
         b_in    = mm_req.b;
         m_in    = mm_req.m;
         r_in    = 32'd0;
      end else if (busy_ff) begin
         r_in   = r_next;
         a_in   = {a_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
      r_ff <= r_in;
   end

   assign mm_rsp.done   = done_ff;
   assign mm_rsp.result = r_ff;

endmodule

@@ hw/rtl/rkx_powmod.sv @@
// ----------------------------------------------------------------------------
// rkx_powmod
// Square-and-multiply sequencer driving the shared modular multiplier.
// ----------------------------------------------------------------------------
module rkx_powmod
   import rkx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  pw_req_type pw_req,
   output pw_rsp_type pw_rsp
);

   pw_state_type state_ff, state_in;
   logic [31:0]  acc_ff, acc_in;
   logic [31:0]  base_ff, base_in;
   logic [31:0]  exp_ff, exp_in;
   logic [31:0]  mod_ff, mod_in;
   logic [4:0]   cnt_ff, cnt_in;

   mm_req_type mm_req;
   mm_rsp_type mm_rsp;

   logic last_bit;

   assign last_bit = (cnt_ff == 5'd31);

   rkx_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PW_IDLE: begin
            if (pw_req.start) begin
               state_in = (pw_req.modulus == 32'd0) ? PW_DONE : PW_REDUCE;
            end
         end
         PW_REDUCE: begin
            if (mm_rsp.done) begin
               state_in = PW_STEP;
            end
         end
         PW_STEP: begin
            if (exp_ff[0]) begin
               state_in = PW_MUL;
            end else begin
               state_in = last_bit ? PW_DONE : PW_SQR;
            end
         end
         PW_MUL: begin
            if (mm_rsp.done) begin
               state_in = last_bit ? PW_DONE : PW_SQR;
            end
         end
         PW_SQR: begin
            if (mm_rsp.done) begin
               state_in = PW_STEP;
            end
         end
         PW_DONE: begin
            state_in = PW_IDLE;
         end
         default: begin
            state_in = PW_IDLE;
         end
      endcase
   end

   always_comb begin
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      cnt_in       = cnt_ff;
      mm_req.start = 1'b0;
      mm_req.a     = base_ff;
      mm_req.b     = base_ff;
      mm_req.m     = mod_ff;
      unique case (state_ff)
         PW_IDLE: begin
            if (pw_req.start) begin
               mod_in = pw_req.modulus;
               exp_in = pw_req.exponent;
               cnt_in = 5'd0;
               acc_in = (pw_req.modulus == 32'd0 || pw_req.modulus == 32'd1) ? 32'd0 : 32'd1;
               mm_req.start = (pw_req.modulus != 32'd0);
               mm_req.a     = pw_req.base;
               mm_req.b     = 32'd1;
               mm_req.m     = pw_req.modulus;
            end
         end
         PW_REDUCE: begin
            if (mm_rsp.done) begin
               base_in = mm_rsp.result;
            end
         end
         PW_STEP: begin
            if (exp_ff[0]) begin
               mm_req.start = 1'b1;
               mm_req.a     = acc_ff;
            end else begin
               mm_req.start = !last_bit;
            end
         end
         PW_MUL: begin
            if (mm_rsp.done) begin
               acc_in       = mm_rsp.result;
               mm_req.start = !last_bit;
            end
         end
         PW_SQR: begin
            if (mm_rsp.done) begin
               base_in = mm_rsp.result;
               exp_in  = {1'b0, exp_ff[31:1]};
               cnt_in  = cnt_ff + 5'd1;
            end
         end
         PW_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PW_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      acc_ff  <= acc_in;
      base_ff <= base_in;
      exp_ff  <= exp_in;
      mod_ff  <= mod_in;
   end

   assign pw_rsp.done   = (state_ff == PW_DONE);
   assign pw_rsp.result = acc_ff;

endmodule

@@ hw/rtl/rsa_keyed_lcg_xor_stream_encoder_top.sv @@
// ----------------------------------------------------------------------------
// rsa_keyed_lcg_xor_stream_encoder_top
// Outgoing byte encoder keyed by a modular exponentiation of an auth word.
// ----------------------------------------------------------------------------
// Items enter on the req_ stream and give exactly one word each on the rsp_
// stream. The csr_ port writes the enable, mode, exponent and modulus
// registers and is always ready; write it only while the block is idle.
// A data byte, a connection reset or an ignored auth word shows its result
// in the cycle after it is taken, so such items flow at one per cycle while
// the receiver keeps rsp_tready high. An auth word that is taken while
// encoding is enabled and no key is held starts the exponentiation: one
// reduction and up to 63 modular products on the shared 32-step multiplier,
// with req_tready low all the while until the result word is loaded. A zero
// modulus skips the multiplier.
// The result word sits in an output register; a new item is taken while it
// is being drained, and a stalled receiver holds off further input.
// Reset clears the registers, the key flag, both stored keys and the output.
// ----------------------------------------------------------------------------
module rsa_keyed_lcg_xor_stream_encoder_top
   import rkx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // auth_word[31:0], data_byte[39:32]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], keyed[8], zero[15:9]
   output logic        rsp_tuser,   // out_is_data[0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   top_state_type state_ff, state_in;

   logic        enable_ff;
   logic        mode_ff;
   logic [31:0] exp_ff;
   logic [31:0] mod_ff;

   logic [31:0] seed_ff, seed_in;
   logic [7:0]  xkey_ff, xkey_in;
   logic        key_held_ff, key_held_in;
   logic [31:0] plain_ff, plain_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_data_ff, rsp_data_in;
   logic        rsp_keyed_ff, rsp_keyed_in;

   logic        req_accept;
   logic        auth_go;
   opcode_type  opcode;
   logic [31:0] lcg_next;

   pw_req_type pw_req;
   pw_rsp_type pw_rsp;

   function automatic logic [7:0] mod255_plus1(input logic [31:0] v);
      logic [9:0] s;
      logic [8:0] t;
      logic [7:0] u;
      s = {2'b00, v[7:0]} + {2'b00, v[15:8]} + {2'b00, v[23:16]} + {2'b00, v[31:24]};
      t = {1'b0, s[7:0]} + {7'd0, s[9:8]};
      u = t[7:0] + {7'd0, t[8]};
      if (u == 8'hFF) begin
         u = 8'd0;
      end
      return u + 8'd1;
   endfunction

   assign opcode     = opcode_type'(req_tuser);
   assign req_tready = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign auth_go    = req_accept && (opcode == OP_AUTH) && enable_ff && !key_held_ff;
   assign lcg_next   = (seed_ff * LcgMul + LcgAdd) & LcgMask;

   assign pw_req.start    = auth_go;
   assign pw_req.base     = req_tdata[31:0];
   assign pw_req.exponent = exp_ff;
   assign pw_req.modulus  = mod_ff;

   rkx_powmod u_powmod (
      .clock  (clock),
      .reset  (reset),
      .pw_req (pw_req),
      .pw_rsp (pw_rsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (auth_go) begin
               state_in = T_POW;
            end
         end
         T_POW: begin
            if (pw_rsp.done) begin
               state_in = T_FIN;
            end
         end
         T_FIN: begin
            state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_comb begin
      seed_in      = seed_ff;
      xkey_in      = xkey_ff;
      key_held_in  = key_held_ff;
      plain_in     = plain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_keyed_in = rsp_keyed_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (req_accept && !auth_go) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = 8'd0;
               rsp_last_in  = 1'b0;
               rsp_data_in  = 1'b0;
               rsp_keyed_in = key_held_ff;
               case (opcode)
                  OP_DATA: begin
                     rsp_byte_in = req_tdata[39:32];
                     rsp_last_in = req_tlast;
                     rsp_data_in = 1'b1;
                     if (enable_ff && key_held_ff) begin
                        if (mode_ff) begin
                           seed_in     = lcg_next;
                           rsp_byte_in = req_tdata[39:32] ^ lcg_next[23:16];
                        end else begin
                           rsp_byte_in = req_tdata[39:32] ^ xkey_ff;
                        end
                     end
                  end
                  OP_RESET: begin
                     key_held_in  = 1'b0;
                     rsp_keyed_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         T_POW: begin
            if (pw_rsp.done) begin
               plain_in = pw_rsp.result;
            end
         end
         T_FIN: begin
            if (mode_ff) begin
               seed_in = plain_ff;
            end else begin
               xkey_in = mod255_plus1(plain_ff);
            end
            key_held_in  = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_byte_in  = 8'd0;
            rsp_last_in  = 1'b0;
            rsp_data_in  = 1'b0;
            rsp_keyed_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         enable_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         exp_ff       <= 32'd0;
         mod_ff       <= 32'd0;
         seed_ff      <= 32'd0;
         xkey_ff      <= 8'd0;
         key_held_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         xkey_ff      <= xkey_in;
         key_held_ff  <= key_held_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_ENABLE:   enable_ff <= csr_data[0];
               REG_MODE:     mode_ff   <= csr_data[0];
               REG_EXPONENT: exp_ff    <= csr_data;
               REG_MODULUS:  mod_ff    <= csr_data;
               default: begin
               end
            endcase
         end
      end
      plain_ff     <= plain_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_keyed_ff <= rsp_keyed_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_keyed_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != T_IDLE) |-> !req_tready)
      else $error("input taken during a key exchange");

   a_done_in_pow: assert property (@(posedge clock) disable iff (reset)
      pw_rsp.done |-> (state_ff == T_POW))
      else $error("exponentiation finished outside a key exchange");

   a_reset_clears_key: assert property (@(posedge clock) disable iff (reset)
      (req_accept && opcode == OP_RESET) |=> (!key_held_ff && rsp_tvalid && !rsp_tdata[8]))
      else $error("connection reset left the key flag set");

   a_fin_sets_key: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_FIN) |=> (key_held_ff && rsp_tvalid && !rsp_tuser))
      else $error("key exchange did not set the key flag");

endmodule
